>>> sv/b64d_pkg.sv
package b64d_pkg;

    // status codes carried on each result
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_ILLEGAL    = 2'd2;

    // character codes
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    // sextet offsets of the alphabet groups
    localparam logic [5:0] SX_LOWER_BASE = 6'd26;
    localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SX_PLUS       = 6'd62;
    localparam logic [5:0] SX_SLASH      = 6'd63;

    // classified character
    typedef struct packed {
        logic       illegal;
        logic [5:0] value;
    } t_sext;

    // one queued job: up to three results sharing flags
    typedef struct packed {
        logic [2:0][7:0] data;    // data[0] goes out first
        logic [1:0]      cnt;     // results in this job, 1..3
        logic            has;     // results carry bytes
        logic [1:0]      status;
        logic            last;    // final result of the job ends the string
    } t_job;

    function automatic t_sext to_sextet(input logic [7:0] c);
        t_sext s;
        logic [7:0] d;
        s.illegal = 1'b0;
        s.value   = '0;
        d         = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d       = c - CH_UPPER_A;
            s.value = d[5:0];
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d       = c - CH_LOWER_A;
            s.value = SX_LOWER_BASE + d[5:0];
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            d       = c - CH_DIGIT_0;
            s.value = SX_DIGIT_BASE + d[5:0];
        end else if (c == CH_PLUS) begin
            s.value = SX_PLUS;
        end else if (c == CH_SLASH) begin
            s.value = SX_SLASH;
        end else if (c == CH_PAD) begin
            s.value = '0;
        end else begin
            s.illegal = 1'b1;
        end
        return s;
    endfunction

endpackage

>>> sv/b64d_front.sv
module b64d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_char,
    input  logic            i_eos,
    input  logic            i_full,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_data,
    output logic            o_push,
    output b64d_pkg::t_job  o_job
);
    import b64d_pkg::*;

    logic [2:0][5:0] r_store;
    logic [2:0][5:0] n_store;
    logic [1:0]      r_qcnt, n_qcnt;
    logic            r_pad3, n_pad3;
    logic            r_swallow, n_swallow;
    logic            r_strict;

    logic   accept;
    t_sext  sx;
    logic   is_pad;
    t_job   job;
    logic   push;

    assign accept = i_valid && !i_full;
    assign sx     = to_sextet(i_char);
    assign is_pad = (i_char == CH_PAD);

    // classify the character and update the quad
    always_comb begin
        n_store   = r_store;
        n_qcnt    = r_qcnt;
        n_pad3    = r_pad3;
        n_swallow = r_swallow;
        push      = 1'b0;
        job.data   = '0;
        job.cnt    = 2'd1;
        job.has    = 1'b0;
        job.status = ST_OK;
        job.last   = 1'b1;
        if (accept) begin
            if (r_swallow) begin
                if (i_eos) begin
                    n_swallow = 1'b0;
                end
            end else if (sx.illegal) begin
                if (r_strict) begin
                    push       = 1'b1;
                    job.status = ST_ILLEGAL;
                    n_qcnt     = '0;
                    n_pad3     = 1'b0;
                    n_swallow  = !i_eos;
                end else if (i_eos) begin
                    push   = 1'b1;
                    n_qcnt = '0;
                    n_pad3 = 1'b0;
                end
            end else if (r_qcnt != 2'd3) begin
                n_store[r_qcnt] = sx.value;
                if (r_qcnt == 2'd2) begin
                    n_pad3 = is_pad;
                end
                n_qcnt = r_qcnt + 2'd1;
                if (i_eos) begin
                    push       = 1'b1;
                    job.status = r_strict ? ST_INCOMPLETE : ST_OK;
                    n_qcnt     = '0;
                    n_pad3     = 1'b0;
                end
            end else begin
                // fourth sextet: emit the decoded bytes
                push        = 1'b1;
                job.has     = 1'b1;
                job.data[0] = {r_store[0], r_store[1][5:4]};
                job.data[1] = {r_store[1][3:0], r_store[2][5:2]};
                job.data[2] = {r_store[2][1:0], sx.value};
                job.cnt     = r_pad3 ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
                job.last    = (job.cnt != 2'd3) || i_eos;
                n_qcnt      = '0;
                n_pad3      = 1'b0;
                n_swallow   = (job.cnt != 2'd3) && !i_eos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        if (!i_rst_n) begin
            r_qcnt    <= '0;
            r_pad3    <= 1'b0;
            r_swallow <= 1'b0;
            r_strict  <= 1'b1;
        end else begin
            r_qcnt    <= n_qcnt;
            r_pad3    <= n_pad3;
            r_swallow <= n_swallow;
            if (i_cfg_valid) begin
                r_strict <= i_cfg_data;
            end
        end
    end

    assign o_push = push;
    assign o_job  = job;

    // characters of a swallowed tail never produce a job
    a_swallow_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_swallow) |-> !push)
        else $error("job pushed while swallowing");

    // a byte job with fewer than three bytes always ends the string
    a_short_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && job.has && job.cnt != 2'd3) |-> job.last)
        else $error("short quad without last");

endmodule

>>> sv/b64d_fifo.sv
module b64d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64d_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nempty,
    output b64d_pkg::t_job  o_head
);
    import b64d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_head   = r_mem[r_rptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nempty)
        else $error("pop from empty queue");

endmodule

>>> sv/b64d_back.sv
module b64d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_nempty,
    input  b64d_pkg::t_job  i_head,
    input  logic            i_stall,
    output logic            o_pop,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_has_byte,
    output logic [1:0]      o_status,
    output logic            o_last
);
    import b64d_pkg::*;

    logic [1:0] r_idx;
    logic       final_res;
    logic       xfer;

    assign final_res = (r_idx + 2'd1 == i_head.cnt);
    assign xfer      = i_nempty && !i_stall;

    // step through the results of the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (xfer) begin
            r_idx <= final_res ? 2'd0 : r_idx + 2'd1;
        end
    end

    assign o_pop      = xfer && final_res;
    assign o_valid    = i_nempty;
    assign o_byte     = i_head.data[r_idx];
    assign o_has_byte = i_head.has;
    assign o_status   = i_head.status;
    assign o_last     = final_res && i_head.last;

    // the result index never runs past the job's count
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_nempty |-> (r_idx < i_head.cnt))
        else $error("result index beyond job");

endmodule

>>> sv/base64_stream_decoder_top.sv
// Channel  Direction  Handshake                  Payload
// in       sink       i_in_valid / o_in_stall    i_in_char, i_end_of_string
// out      source     o_out_valid / i_out_stall  o_out_byte, o_has_byte, o_status, o_last
// cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_data (strict_check)
//
// One character is taken per cycle while o_in_stall is low; a decoded quad leaves as up
// to three results, one per cycle while i_out_stall is low, from a job queue of
// FIFO_DEPTH entries, so one character per cycle is sustained without output stalls.
// o_in_stall rises only when the job queue is full; o_out_valid follows the queue.
// Synchronous active-low reset empties the queue, clears the quad and sets strict mode.
// The config port is always ready.
module base64_stream_decoder_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic [1:0] o_status,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import b64d_pkg::*;

    logic  push, pop, full, nempty;
    t_job  job, head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_char      (i_in_char),
        .i_eos       (i_end_of_string),
        .i_full      (full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_job       (job)
    );

    b64d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_full   (full),
        .o_nempty (nempty),
        .o_head   (head)
    );

    b64d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nempty   (nempty),
        .i_head     (head),
        .i_stall    (i_out_stall),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .o_byte     (o_out_byte),
        .o_has_byte (o_has_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    // a result carrying a byte is always ok
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_has_byte) |-> (o_status == ST_OK))
        else $error("byte result with error status");

endmodule
